/* hdl/text_to_unsigned_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text_to_unsigned_parser block
// Concurrent checks on i_clk; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_UNSIGNED_PARSER_ASSERT_SVH
`define TEXT_TO_UNSIGNED_PARSER_ASSERT_SVH

`ifndef SYNTH
// checked outside reset
`define TTUP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: assertion failed");
// checked in every cycle, reset included
`define TTUP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("%m: assertion failed");
`else
`define TTUP_ASSERT(lbl, prop)
`define TTUP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* hdl/ttup_pkg.sv */
// ----------------------------------------------------------------------------
// ttup_pkg
// Types, codes and character helpers shared by the unsigned number parser.
// ----------------------------------------------------------------------------
package ttup_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    localparam int BASE_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_PREFIX = 2'd1;

    localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] DIGIT_NONE = 8'hFF;

    typedef struct packed {
        logic                emit;
        logic [STATUS_W-1:0] status;
        logic                digits_seen;
    } t_result_info;

    // digit value of a character, DIGIT_NONE when it is no digit at all
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = DIGIT_NONE;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d = c - CH_ZERO;
        end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            d = c - CH_UP_A + 8'd10;
        end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
            d = c - CH_LO_A + 8'd10;
        end
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {[CH_TAB:CH_CR], CH_SPACE});
    endfunction

endpackage

/* hdl/ttup_core.sv */
// ----------------------------------------------------------------------------
// ttup_core
// Parse state and the per-character step: one multiply-add by the base.
// ----------------------------------------------------------------------------
module ttup_core
    import ttup_pkg::*;
#(
    parameter int VALUE_WIDTH  = 64,
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [7:0]              i_ch,
    input  logic                    i_first,
    input  logic [BASE_W-1:0]       i_number_base,
    input  logic                    i_allow_prefix,
    output t_result_info            o_info,
    output logic [VALUE_WIDTH-1:0]  o_value,
    output logic [OFFSET_WIDTH-1:0] o_offset
);

    localparam int PROD_W = VALUE_WIDTH + BASE_W + 1;

    t_phase                  r_phase, n_phase;
    logic [VALUE_WIDTH-1:0]  r_acc, n_acc;
    logic                    r_ovf, n_ovf;
    logic                    r_any, n_any;
    logic                    r_neg, n_neg;
    logic [BASE_W-1:0]       r_base, n_base;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;

    // state as seen by this character (a first character restarts the parse)
    t_phase                  e_phase;
    logic [VALUE_WIDTH-1:0]  e_acc;
    logic                    e_ovf, e_any, e_neg;
    logic [BASE_W-1:0]       e_base;
    logic [OFFSET_WIDTH-1:0] e_pos;

    logic              start, feed, refuse, dig_ok, accept, stop;
    logic [BASE_W-1:0] base_f;
    logic              any_f, neg_f;
    logic [7:0]        dval;
    logic [PROD_W-1:0] prod;
    logic              prod_ovf;

    always_comb begin
        if (i_first) begin
            e_phase = PH_SPACE;
            e_acc   = '0;
            e_ovf   = 1'b0;
            e_any   = 1'b0;
            e_neg   = 1'b0;
            e_base  = i_number_base;
            e_pos   = '0;
        end else begin
            e_phase = r_phase;
            e_acc   = r_acc;
            e_ovf   = r_ovf;
            e_any   = r_any;
            e_neg   = r_neg;
            e_base  = r_base;
            e_pos   = r_pos;
        end
    end

    assign dval     = digit_value(i_ch);
    assign prod     = (PROD_W'(e_acc) * PROD_W'(base_f)) + PROD_W'(dval[BASE_W-1:0]);
    assign prod_ovf = |prod[PROD_W-1:VALUE_WIDTH];

    // next state
    always_comb begin
        n_phase = e_phase;
        base_f  = e_base;
        any_f   = e_any;
        neg_f   = e_neg;
        start   = 1'b0;
        feed    = 1'b0;
        refuse  = 1'b0;
        case (e_phase)
            PH_IDLE: begin
            end
            PH_SPACE: begin
                if (is_space(i_ch)) begin
                end else if (e_base == '0 && !i_allow_prefix) begin
                    refuse = 1'b1;
                end else if (i_ch == CH_MINUS || i_ch == CH_PLUS) begin
                    if (!i_allow_prefix) begin
                        refuse = 1'b1;
                    end else begin
                        neg_f   = (i_ch == CH_MINUS);
                        n_phase = PH_SIGNED;
                    end
                end else begin
                    start = 1'b1;
                end
            end
            PH_SIGNED: begin
                start = 1'b1;
            end
            PH_ZERO: begin
                if (i_ch == CH_LO_X || i_ch == CH_UP_X) begin
                    if (!i_allow_prefix) begin
                        refuse = 1'b1;
                    end else begin
                        base_f  = BASE_HEX;
                        n_phase = PH_DIGITS;
                    end
                end else begin
                    // the leading zero counts as a digit; accumulator is still zero
                    if (e_base == '0) begin
                        base_f = BASE_OCT;
                    end
                    any_f   = 1'b1;
                    n_phase = PH_DIGITS;
                    feed    = 1'b1;
                end
            end
            PH_DIGITS: begin
                feed = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (start) begin
            if ((e_base == '0 || e_base == BASE_HEX) && i_ch == CH_ZERO) begin
                n_phase = PH_ZERO;
            end else begin
                if (e_base == '0) begin
                    base_f = BASE_DEC;
                end
                n_phase = PH_DIGITS;
                feed    = 1'b1;
            end
        end

        dig_ok = (base_f != '0) && (dval < {2'b00, base_f});
        accept = feed && dig_ok;
        stop   = feed && !dig_ok;
        if (refuse || stop) begin
            n_phase = PH_IDLE;
        end

        n_base = base_f;
        n_neg  = neg_f;
        n_any  = any_f || accept;
        n_acc  = e_acc;
        n_ovf  = e_ovf;
        if (accept) begin
            if (e_ovf || prod_ovf) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = prod[VALUE_WIDTH-1:0];
            end
        end
        n_pos = (e_phase != PH_IDLE && e_pos != '1) ? e_pos + OFFSET_WIDTH'(1) : e_pos;
    end

    // outputs
    always_comb begin
        o_info.emit = refuse || stop;
        if (refuse) begin
            o_info.status      = ST_REFUSED;
            o_info.digits_seen = 1'b0;
            o_value            = '0;
            o_offset           = '0;
        end else if (e_ovf) begin
            o_info.status      = ST_OVERFLOW;
            o_info.digits_seen = 1'b1;
            o_value            = '1;
            o_offset           = e_pos;
        end else begin
            o_info.status      = ST_OK;
            o_info.digits_seen = any_f;
            o_value            = neg_f ? (VALUE_WIDTH'(0) - e_acc) : e_acc;
            o_offset           = any_f ? e_pos : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_any   <= 1'b0;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_any   <= n_any;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_pos   <= n_pos;
        end
    end

endmodule

/* hdl/text_to_unsigned_parser.sv */
// ----------------------------------------------------------------------------
// text_to_unsigned_parser
// Streaming character-to-unsigned-integer parser, one character per word.
// ----------------------------------------------------------------------------
// Input stream: tdata carries one character, tuser marks the first character
// of a string; a first character drops any parse still in progress.
// Output stream: one word per finished string, carrying value and end offset
// in tdata, status and digits-seen flag in tuser. Characters outside a string
// (after a result, before the next first) produce nothing.
// Config channel: index 0 sets the number base (0 = detect), index 1 the
// prefix permission. Write only while the parser is idle; always ready.
// Result path: the terminating character is taken into the input register,
// its result word into the result register, which drives the master side.
// Throughput: one character per cycle unless the master side stalls; the
// per-character step is a single multiply-add of the accumulator by the
// base plus a carry-out check.
// Reset: config returns to base 10 with prefixes allowed, parse state idle,
// both registers empty.
// A stalled master side holds its word; the input register then fills and
// s_tready drops until the result word is taken.
// ----------------------------------------------------------------------------
`include "text_to_unsigned_parser_assert.svh"

module text_to_unsigned_parser
    import ttup_pkg::*;
#(
    parameter int VALUE_WIDTH  = 64,
    parameter int OFFSET_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] ch
    input  logic [0:0]            i_s_tuser,   // [0] first
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // value (low VALUE_WIDTH bits), then end_offset, zero padded to bytes
    output logic [((VALUE_WIDTH+OFFSET_WIDTH+7)/8)*8-1:0] o_m_tdata,
    output logic [STATUS_W:0]     o_m_tuser,   // [1:0] status, [2] digits_seen
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DATA_W = ((VALUE_WIDTH + OFFSET_WIDTH + 7) / 8) * 8;

    logic [BASE_W-1:0] r_number_base;
    logic              r_allow_prefix;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_first;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [STATUS_W:0] r_out_user;

    logic                    advance;
    t_result_info            info;
    logic [VALUE_WIDTH-1:0]  res_value;
    logic [OFFSET_WIDTH-1:0] res_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base  <= BASE_DEC;
            r_allow_prefix <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_NUMBER_BASE) begin
                r_number_base <= i_cfg_data[BASE_W-1:0];
            end else if (i_cfg_index == CFG_ALLOW_PREFIX) begin
                r_allow_prefix <= i_cfg_data[0];
            end
        end
    end

    // the step runs when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_ch    <= i_s_tdata;
            r_in_first <= i_s_tuser[0];
        end
    end

    ttup_core #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_ch           (r_in_ch),
        .i_first        (r_in_first),
        .i_number_base  (r_number_base),
        .i_allow_prefix (r_allow_prefix),
        .o_info         (info),
        .o_value        (res_value),
        .o_offset       (res_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= info.emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && info.emit) begin
            r_out_data <= DATA_W'({res_offset, res_value});
            r_out_user <= {info.digits_seen, info.status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    `TTUP_ASSERT(a_refused_word_clear,
        (o_m_tvalid && o_m_tuser[STATUS_W-1:0] == ST_REFUSED) |->
            (o_m_tdata == '0 && !o_m_tuser[STATUS_W]))
    `TTUP_ASSERT(a_overflow_all_ones,
        (o_m_tvalid && o_m_tuser[STATUS_W-1:0] == ST_OVERFLOW) |->
            (o_m_tdata[VALUE_WIDTH-1:0] == '1 && o_m_tuser[STATUS_W]))
    `TTUP_ASSERT(a_no_digits_no_offset,
        (o_m_tvalid && !o_m_tuser[STATUS_W]) |->
            (r_out_data[VALUE_WIDTH +: OFFSET_WIDTH] == '0))
    `TTUP_ASSERT(a_step_only_with_room,
        advance |-> (r_in_valid && (!r_out_valid || i_m_tready)))
    `TTUP_ASSERT_ALWAYS(a_reset_empties,
        !i_rst_n |=> (!r_in_valid && !r_out_valid))

endmodule
